// ----- rtl/median_of_two_sorted_arrays_macros.svh -----
// ----------------------------------------------------------------------------
// median of two sorted arrays: assertion macros
// shared check macros; each expects clk and rst in the enclosing module
// ----------------------------------------------------------------------------
`ifndef MEDIAN_OF_TWO_SORTED_ARRAYS_MACROS_SVH
`define MEDIAN_OF_TWO_SORTED_ARRAYS_MACROS_SVH

// same-cycle implication
`define MOTSA_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("motsa check failed");

// next-cycle implication
`define MOTSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("motsa check failed");

`endif

// ----- rtl/motsa_pkg.sv -----
// ----------------------------------------------------------------------------
// motsa_pkg
// request codes, status codes and controller/datapath interface structs
// ----------------------------------------------------------------------------
package motsa_pkg;

  // request codes on req_type
  typedef enum logic [1:0] {
    REQ_LOAD_FIRST  = 2'd0,
    REQ_LOAD_SECOND = 2'd1,
    REQ_COMPUTE     = 2'd2
  } req_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_OVERFLOW = 2'd2
  } stat_t;

  // controller to datapath commands
  typedef struct packed {
    logic store_first;   // append to first store
    logic store_second;  // append to second store
    logic start;         // latch sizes, clear counts
    logic pick;          // choose next split or settle on lower bound
    logic addr_hi;       // 0: lg[j-1]/sh[i], 1: lg[j]/sh[i-1]
    logic capture;       // capture first read pair
    logic evaluate;      // capture second pair and move bounds
    logic result_load;   // load output registers
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic both_empty;    // no elements in either store
    logic settled;       // split is final after this evaluation
  } sts_t;

endpackage

// ----- rtl/median_of_two_sorted_arrays.sv -----
// ----------------------------------------------------------------------------
// median_of_two_sorted_arrays
// sequencing: a load request is appended to its store; a compute runs
//   search steps over the shorter length n (pick, two reads, evaluate), then
//   loads the result register; an empty compute goes straight to the load
// requests: one request at a time, set by the search steps over the ram
//   read port; loads are taken while a finished result waits
// reset: counts and overflow flag clear; stores are not cleared
// ----------------------------------------------------------------------------
module median_of_two_sorted_arrays #(
  parameter int MAX_LEN    = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   req_type,
  input  logic signed [DATA_WIDTH-1:0] value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH:0]   median_doubled,
  output logic [1:0]                   status
);
  import motsa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  motsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // stores and search datapath
  motsa_dp #(.MAX_LEN(MAX_LEN), .DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .value          (value),
    .cmd            (cmd),
    .sts            (sts),
    .median_doubled (median_doubled),
    .status         (status)
  );

endmodule

// ----- rtl/motsa_ram.sv -----
// ----------------------------------------------------------------------------
// motsa_ram
// simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module motsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/motsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// motsa_ctrl
// request sequencer: loads, split search steps and result handoff
// ----------------------------------------------------------------------------
`include "median_of_two_sorted_arrays_macros.svh"

module motsa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      req_type,
  output logic            out_valid,
  input  logic            out_stall,
  input  motsa_pkg::sts_t sts,
  output motsa_pkg::cmd_t cmd
);
  import motsa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RD1,
    S_RD2,
    S_EVAL,
    S_DONE
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   accept;
  req_t   req;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign req      = req_t'(req_type);

  // next state and commands
  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && out_stall;
    cmd            = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req)
            REQ_LOAD_FIRST:  cmd.store_first = 1'b1;
            REQ_LOAD_SECOND: cmd.store_second = 1'b1;
            REQ_COMPUTE: begin
              cmd.start  = 1'b1;
              state_next = sts.both_empty ? S_DONE : S_CHECK;
            end
            default: ;
          endcase
        end
      end
      S_CHECK: begin
        cmd.pick   = 1'b1;
        state_next = S_RD1;
      end
      S_RD1: begin
        state_next = S_RD2;
      end
      S_RD2: begin
        cmd.addr_hi = 1'b1;
        cmd.capture = 1'b1;
        state_next  = S_EVAL;
      end
      S_EVAL: begin
        cmd.evaluate = 1'b1;
        state_next   = sts.settled ? S_DONE : S_CHECK;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.result_load = 1'b1;
          out_valid_next  = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `MOTSA_ASSERT_NEXT(a_start_searches, cmd.start && !sts.both_empty, state == S_CHECK)
  `MOTSA_ASSERT_NEXT(a_done_holds, state == S_DONE && out_valid && out_stall, state == S_DONE && out_valid)
  `MOTSA_ASSERT(a_no_overwrite, cmd.result_load, !out_valid || !out_stall)

endmodule

// ----- rtl/motsa_dp.sv -----
// ----------------------------------------------------------------------------
// motsa_dp
// element stores, counts, split search registers and result arithmetic
// ----------------------------------------------------------------------------
`include "median_of_two_sorted_arrays_macros.svh"

module motsa_dp #(
  parameter int MAX_LEN    = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic signed [DATA_WIDTH-1:0] value,
  input  motsa_pkg::cmd_t              cmd,
  output motsa_pkg::sts_t              sts,
  output logic signed [DATA_WIDTH:0]   median_doubled,
  output logic [1:0]                   status
);
  import motsa_pkg::*;

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam logic [CW-1:0] FULL = CW'(MAX_LEN);

  // load side
  logic [CW-1:0] cnt_a, cnt_b;
  logic          ovf;

  // search registers
  logic [CW-1:0] m, n, half, lo, hi, i;
  logic          fin, swap, odd, empty, ovf_seen;
  logic signed [DATA_WIDTH-1:0] a, b, c, d;

  // ram ports
  logic [DATA_WIDTH-1:0] rd_a, rd_b;
  logic [AW-1:0]         raddr_a, raddr_b, lg_addr, sh_addr;
  logic signed [DATA_WIDTH-1:0] lg_rd, sh_rd;
  logic                  we_a, we_b;

  logic [CW-1:0] j, j_m1, i_m1, cnt_lg, cnt_sh;
  logic [CW:0]   lohi_sum, tot;
  logic          swap_now, cond_lo, cond_hi;
  logic signed [DATA_WIDTH-1:0] left, right;
  logic signed [DATA_WIDTH:0]   left_ext, right_ext, sum;

  // store writes
  assign we_a = cmd.store_first && (cnt_a != FULL);
  assign we_b = cmd.store_second && (cnt_b != FULL);

  motsa_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_LEN)) u_ram_first (
    .clk   (clk),
    .we    (we_a),
    .waddr (cnt_a[AW-1:0]),
    .wdata (value),
    .raddr (raddr_a),
    .rdata (rd_a)
  );

  motsa_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_LEN)) u_ram_second (
    .clk   (clk),
    .we    (we_b),
    .waddr (cnt_b[AW-1:0]),
    .wdata (value),
    .raddr (raddr_b),
    .rdata (rd_b)
  );

  // longer array becomes lg; ties keep the first array
  assign swap_now = (cnt_a < cnt_b);
  assign cnt_lg   = swap_now ? cnt_b : cnt_a;
  assign cnt_sh   = swap_now ? cnt_a : cnt_b;
  assign tot      = {1'b0, cnt_lg} + {1'b0, cnt_sh} + {{CW{1'b0}}, 1'b1};

  assign sts.both_empty = (cnt_a == '0) && (cnt_b == '0);

  // split addresses
  assign j        = half - i;
  assign j_m1     = j - 1'b1;
  assign i_m1     = i - 1'b1;
  assign lg_addr  = cmd.addr_hi ? j[AW-1:0] : j_m1[AW-1:0];
  assign sh_addr  = cmd.addr_hi ? i_m1[AW-1:0] : i[AW-1:0];
  assign raddr_a  = swap ? sh_addr : lg_addr;
  assign raddr_b  = swap ? lg_addr : sh_addr;
  assign lg_rd    = swap ? rd_b : rd_a;
  assign sh_rd    = swap ? rd_a : rd_b;
  assign lohi_sum = {1'b0, lo} + {1'b0, hi};

  // bound moves: a = lg[j-1], b = sh[i], sh_rd = sh[i-1], lg_rd = lg[j]
  assign cond_lo     = (i < n) && (j != '0) && (a > b);
  assign cond_hi     = (i != '0) && (j < m) && (sh_rd > lg_rd);
  assign sts.settled = fin || !(cond_lo || cond_hi);

  // left max and right min at the final split
  always_comb begin
    if (i != '0 && j != '0) begin
      left = (c > a) ? c : a;
    end else if (i != '0) begin
      left = c;
    end else begin
      left = a;
    end
    if (i < n && j < m) begin
      right = (b < d) ? b : d;
    end else if (i < n) begin
      right = b;
    end else begin
      right = d;
    end
    left_ext  = {left[DATA_WIDTH-1], left};
    right_ext = {right[DATA_WIDTH-1], right};
    sum       = left_ext + (odd ? left_ext : right_ext);
  end

  // counts and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_a <= '0;
      cnt_b <= '0;
      ovf   <= 1'b0;
    end else if (cmd.start) begin
      cnt_a <= '0;
      cnt_b <= '0;
      ovf   <= 1'b0;
    end else begin
      if (cmd.store_first) begin
        if (we_a) begin
          cnt_a <= cnt_a + 1'b1;
        end else begin
          ovf <= 1'b1;
        end
      end
      if (cmd.store_second) begin
        if (we_b) begin
          cnt_b <= cnt_b + 1'b1;
        end else begin
          ovf <= 1'b1;
        end
      end
    end
  end

  // search bounds
  always_ff @(posedge clk) begin
    if (rst) begin
      m   <= '0;
      n   <= '0;
      lo  <= '0;
      hi  <= '0;
      i   <= '0;
      fin <= 1'b0;
    end else if (cmd.start) begin
      m   <= cnt_lg;
      n   <= cnt_sh;
      lo  <= '0;
      hi  <= cnt_sh;
      i   <= '0;
      fin <= 1'b0;
    end else if (cmd.pick) begin
      if (lo > hi) begin
        i   <= lo;
        fin <= 1'b1;
      end else begin
        i <= lohi_sum[CW:1];
      end
    end else if (cmd.evaluate && !fin) begin
      if (cond_lo) begin
        lo <= i + 1'b1;
      end else if (cond_hi) begin
        hi <= i_m1;
      end
    end
  end

  // per-compute payload registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      half     <= tot[CW:1];
      swap     <= swap_now;
      odd      <= cnt_a[0] ^ cnt_b[0];
      empty    <= sts.both_empty;
      ovf_seen <= ovf;
    end
    if (cmd.capture) begin
      a <= lg_rd;
      b <= sh_rd;
    end
    if (cmd.evaluate) begin
      c <= sh_rd;
      d <= lg_rd;
    end
  end

  // output registers
  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      if (empty) begin
        median_doubled <= '0;
        status         <= ST_EMPTY;
      end else begin
        median_doubled <= sum;
        status         <= ovf_seen ? ST_OVERFLOW : ST_OK;
      end
    end
  end

  `MOTSA_ASSERT(a_counts_bounded, 1'b1, cnt_a <= FULL && cnt_b <= FULL)
  `MOTSA_ASSERT_NEXT(a_full_load_flags, cmd.store_first && !cmd.start && cnt_a == FULL, ovf)
  `MOTSA_ASSERT(a_search_bounds, 1'b1, lo <= n && hi <= n && i <= n)

endmodule

// ----- sim/median_of_two_sorted_arrays_tb.sv -----
// ----------------------------------------------------------------------------
// median_of_two_sorted_arrays_tb
// streams load and compute requests into the median block. A scoreboard
// mirrors both stores and predicts twice the median and the status
// of every compute request. Both handshakes idle in random bursts, and the
// result side holds off once for a long stretch to back up the request side.
// ----------------------------------------------------------------------------
module median_of_two_sorted_arrays_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import motsa_pkg::*;

  localparam int MAX_LEN = 1024;
  localparam int DATA_WIDTH = 32;
  localparam logic [1:0] REQ_IGNORED = 2'd3;
  localparam longint DATA_MIN = -(longint'(1) <<< (DATA_WIDTH - 1));
  localparam longint DATA_MAX = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
  localparam int ITEM_TARGET = 800;
  localparam int RESULT_TARGET = 30;
  localparam int CALM_TAIL = 150;
  localparam int HOLD_AFTER = 15;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic [1:0]                   code;
    logic signed [DATA_WIDTH-1:0] data;
  } request_t;

  typedef struct {
    logic signed [DATA_WIDTH:0] doubled;
    stat_t                      stat;
  } median_result_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [1:0]                   req_type = REQ_LOAD_FIRST;
  logic signed [DATA_WIDTH-1:0] value = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [DATA_WIDTH:0]   median_doubled;
  logic [1:0]                   status;

  request_t       pending_requests[$];
  median_result_t expected_medians[$];

  // scoreboard copy of the stores
  longint first_vals[MAX_LEN];
  longint second_vals[MAX_LEN];
  int     first_len = 0;
  int     second_len = 0;
  bit     overflow_seen = 1'b0;

  int error_count = 0;
  int results_seen = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int cycle_count = 0;

  median_of_two_sorted_arrays #(
    .MAX_LEN(MAX_LEN),
    .DATA_WIDTH(DATA_WIDTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .value(value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .median_doubled(median_doubled),
    .status(status)
  );

  always #1 clk = ~clk;

  // element of the first or second store
  function automatic longint stored(bit from_first, int idx);
    return from_first ? first_vals[idx] : second_vals[idx];
  endfunction

  // binary search for the split over the shorter array
  function automatic longint predict_twice_median(bit first_long);
    int m, n, half, lo, hi, i, j;
    longint left, right;
    m = first_long ? first_len : second_len;
    n = first_long ? second_len : first_len;
    if (n == 0) return stored(first_long, m / 2) + stored(first_long, (m - 1) / 2);
    half = (m + n + 1) / 2;
    lo = 0;
    hi = n;
    i = 0;
    forever begin
      if (lo > hi) begin
        i = lo;
        break;
      end
      i = (lo + hi) / 2;
      j = half - i;
      if (i < n && j > 0 && stored(first_long, j - 1) > stored(!first_long, i)) begin
        lo = i + 1;
      end else if (i > 0 && j < m && stored(!first_long, i - 1) > stored(first_long, j)) begin
        hi = i - 1;
      end else begin
        break;
      end
    end
    j = half - i;
    if (i > 0 && j > 0) begin
      left = stored(!first_long, i - 1) > stored(first_long, j - 1) ?
             stored(!first_long, i - 1) : stored(first_long, j - 1);
    end else if (i > 0) begin
      left = stored(!first_long, i - 1);
    end else begin
      left = stored(first_long, j - 1);
    end
    if (((m + n) % 2) != 0) return left + left;
    if (i < n && j < m) begin
      right = stored(!first_long, i) < stored(first_long, j) ?
              stored(!first_long, i) : stored(first_long, j);
    end else if (i < n) begin
      right = stored(!first_long, i);
    end else begin
      right = stored(first_long, j);
    end
    return left + right;
  endfunction

  // update the store copy and queue the expected median
  function automatic void absorb_request(logic [1:0] code, logic signed [DATA_WIDTH-1:0] data);
    median_result_t res;
    case (code)
      REQ_LOAD_FIRST: begin
        if (first_len < MAX_LEN) begin
          first_vals[first_len] = longint'(data);
          first_len++;
        end else begin
          overflow_seen = 1'b1;
        end
      end
      REQ_LOAD_SECOND: begin
        if (second_len < MAX_LEN) begin
          second_vals[second_len] = longint'(data);
          second_len++;
        end else begin
          overflow_seen = 1'b1;
        end
      end
      REQ_COMPUTE: begin
        if (first_len == 0 && second_len == 0) begin
          res.doubled = '0;
          res.stat = ST_EMPTY;
        end else begin
          res.doubled = (DATA_WIDTH + 1)'(predict_twice_median(first_len >= second_len));
          res.stat = overflow_seen ? ST_OVERFLOW : ST_OK;
        end
        expected_medians.push_back(res);
        first_len = 0;
        second_len = 0;
        overflow_seen = 1'b0;
      end
      default: begin
      end
    endcase
  endfunction

  // compare one result against the oldest expected median
  function automatic void check_result(logic signed [DATA_WIDTH:0] got_doubled,
                                       logic [1:0] got_stat);
    median_result_t want;
    if (expected_medians.size() == 0) begin
      $error("unexpected result: median_doubled %0d status %0d", got_doubled, got_stat);
      error_count++;
      return;
    end
    want = expected_medians.pop_front();
    results_seen++;
    if (got_doubled !== want.doubled) begin
      $error("median_doubled: expected %0d, actual %0d", want.doubled, got_doubled);
      error_count++;
    end
    if (got_stat !== want.stat) begin
      $error("status: expected %0d, actual %0d", want.stat, got_stat);
      error_count++;
    end
  endfunction

  task automatic push_request(logic [1:0] code, logic signed [DATA_WIDTH-1:0] data);
    request_t req;
    req.code = code;
    req.data = data;
    pending_requests.push_back(req);
  endtask

  // two runs, ascending unless scrambled, interleaved and closed by a compute
  task automatic queue_set(int len_first, int len_second, bit scramble);
    logic signed [DATA_WIDTH-1:0] first_run[$];
    logic signed [DATA_WIDTH-1:0] second_run[$];
    longint level;
    longint step;
    int mode;
    int len;
    for (int side = 0; side < 2; side++) begin
      len = side ? len_second : len_first;
      mode = $urandom_range(0, 3);
      case ($urandom_range(0, 4))
        0: level = DATA_MIN;
        1: level = DATA_MAX - $urandom_range(0, 50);
        2: level = longint'($urandom_range(0, 200)) - 100;
        default: level = longint'(int'($urandom));
      endcase
      for (int k = 0; k < len; k++) begin
        if (k > 0) begin
          case (mode)
            0: step = 0;
            1: step = $urandom_range(0, 3);
            2: step = $urandom_range(0, 100000);
            default: step = longint'($urandom) >> $urandom_range(0, 8);
          endcase
          level = level + step;
          if (level > DATA_MAX) level = DATA_MAX;
        end
        if (scramble && $urandom_range(0, 2) == 0) level = longint'(int'($urandom));
        if (side == 0) first_run.push_back(level[DATA_WIDTH-1:0]);
        else second_run.push_back(level[DATA_WIDTH-1:0]);
      end
    end
    while (first_run.size() + second_run.size() > 0) begin
      if ($urandom_range(0, 19) == 0) push_request(REQ_IGNORED, $urandom);
      if (second_run.size() == 0 || (first_run.size() > 0 && $urandom_range(0, 1) == 0))
        push_request(REQ_LOAD_FIRST, first_run.pop_front());
      else
        push_request(REQ_LOAD_SECOND, second_run.pop_front());
    end
    if ($urandom_range(0, 19) == 0) push_request(REQ_IGNORED, $urandom);
    push_request(REQ_COMPUTE, $urandom);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) absorb_request(req_type, value);
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_requests.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_requests.size() >= CALM_TAIL && $urandom_range(0, 7) == 0) begin
          send_gap <= $urandom_range(0, 9);
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          req_type <= pending_requests[0].code;
          value <= pending_requests[0].data;
          pending_requests.pop_front();
        end
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result(median_doubled, status);
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        // long hold-off so the block backs up the request side
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= 1'b1;
      end else if (pending_requests.size() >= CALM_TAIL && $urandom_range(0, 7) == 0) begin
        recv_gap <= $urandom_range(0, 9);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int random_items;
    int random_results;
    int pick;
    int len_a;
    int len_b;
    random_items = 0;
    random_results = 0;

    // directed: both empty, single extremes, shorter side empty
    push_request(REQ_COMPUTE, '0);
    push_request(REQ_LOAD_FIRST, DATA_MAX[DATA_WIDTH-1:0]);
    push_request(REQ_COMPUTE, '1);
    push_request(REQ_LOAD_SECOND, DATA_MIN[DATA_WIDTH-1:0]);
    push_request(REQ_LOAD_SECOND, DATA_MIN[DATA_WIDTH-1:0]);
    push_request(REQ_COMPUTE, '0);
    // equal lengths across the full range, with an ignored code in between
    push_request(REQ_IGNORED, '1);
    push_request(REQ_LOAD_FIRST, DATA_MIN[DATA_WIDTH-1:0]);
    push_request(REQ_LOAD_SECOND, DATA_MAX[DATA_WIDTH-1:0]);
    push_request(REQ_COMPUTE, '0);
    // odd total, interleaved runs
    push_request(REQ_LOAD_FIRST, 1);
    push_request(REQ_LOAD_SECOND, 2);
    push_request(REQ_LOAD_FIRST, 3);
    push_request(REQ_LOAD_SECOND, 4);
    push_request(REQ_LOAD_FIRST, 5);
    push_request(REQ_COMPUTE, '0);
    // unsorted data
    push_request(REQ_LOAD_FIRST, 9);
    push_request(REQ_LOAD_FIRST, -4);
    push_request(REQ_LOAD_FIRST, 7);
    push_request(REQ_LOAD_SECOND, 100);
    push_request(REQ_LOAD_SECOND, -50);
    push_request(REQ_COMPUTE, '0);
    // ignored code alone, then counts must read empty again
    push_request(REQ_IGNORED, '0);
    push_request(REQ_COMPUTE, '1);

    // random sets of mixed lengths
    while (random_items < ITEM_TARGET || random_results < RESULT_TARGET) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        len_a = 0;
        len_b = 0;
      end else if (pick == 1) begin
        len_a = $urandom_range(0, 200);
        len_b = $urandom_range(0, 200);
      end else begin
        len_a = $urandom_range(0, 12);
        len_b = (pick < 5) ? len_a : $urandom_range(0, 12);
      end
      queue_set(len_a, len_b, $urandom_range(0, 7) == 0);
      random_items += len_a + len_b + 1;
      random_results++;
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || in_valid || expected_medians.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && expected_medians.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
